### rtl/aald_pkg.sv
// aald_pkg: request and result word types and request codes for the
// antialiased line drawer; no dependencies
package aald_pkg;

  typedef enum logic [1:0] {
    REQ_LINE  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [7:0]         ink;
    logic [6:0]         pixel_col;
    logic [6:0]         pixel_row;
    logic [7:0]         pixel_value;
  } req_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       was_read;
  } res_t;

endpackage

### rtl/antialiased_line_drawer_top.sv
// antialiased_line_drawer_top: line drawer with a synchronous framebuffer memory
// depends on aald_pkg
//
//   channel | signals               | direction | handshake
//   request | start_i, req_i, busy_o | in        | start_i & !busy_o
//   result  | done_o, res_o          | out       | done_o, one cycle, no stall
//
// pixel write: S_PIX then S_DONE; a pixel read adds S_RDRES. line: a setup step, a 37-step
// serial divider plus one step to sign the gradient (one quotient bit a cycle),
// then per major column S_COL, S_MUL and S_PXA for each side, plus S_RDWT, S_BLND and
// S_WR for each of its up to two read-modify-writes on the single framebuffer port.
// reset clears control only; framebuffer contents are undefined until written.
// the result strobe is one cycle wide and cannot be held off.
module antialiased_line_drawer_top #(
  parameter int IMG_WIDTH  = 128,
  parameter int IMG_HEIGHT = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  aald_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output aald_pkg::res_t res_o
);

  localparam int Depth = IMG_WIDTH * IMG_HEIGHT;
  localparam int AW    = $clog2(Depth);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_PIX   = 12'b000000000010,
    S_RDRES = 12'b000000000100,
    S_SETUP = 12'b000000001000,
    S_DIV   = 12'b000000010000,
    S_COL   = 12'b000000100000,
    S_MUL   = 12'b000001000000,
    S_PXA   = 12'b000010000000,
    S_RDWT  = 12'b000100000000,
    S_BLND  = 12'b001000000000,
    S_WR    = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // framebuffer memory, one port, registered read
  logic [7:0]    mem [Depth];
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata_q <= mem[mem_addr];
  end

  // working registers
  aald_pkg::req_t     req_q;
  logic               steep_q, pix_in_q, side_q;
  logic signed [16:0] x0_q, y0_q, dx_q;
  logic signed [16:0] u_q, last_q;
  logic [16:0]        rem_q;
  logic [36:0]        quo_q;
  logic [5:0]         cnt_q;
  logic               neg_q;
  logic signed [17:0] g_q;
  logic signed [63:0] ypos_q;
  logic signed [43:0] base_q;
  logic [7:0]         f_q;
  logic [AW-1:0]      addr_q;
  logic [8:0]         alpha_q;
  logic [7:0]         blend_q;
  aald_pkg::res_t     res_q;
  logic               done_q;

  // endpoint ordering
  logic signed [16:0] ax0, ay0, ax1, ay1, adx, ady, sx0, sy0, sx1, sy1;
  logic               stp;
  always_comb begin
    ax0 = 17'(req_q.start_x);
    ay0 = 17'(req_q.start_y);
    ax1 = 17'(req_q.end_x);
    ay1 = 17'(req_q.end_y);
    adx = (ax1 >= ax0) ? ax1 - ax0 : ax0 - ax1;
    ady = (ay1 >= ay0) ? ay1 - ay0 : ay0 - ay1;
    stp = ady > adx;
    sx0 = stp ? ay0 : ax0;
    sy0 = stp ? ax0 : ay0;
    sx1 = stp ? ay1 : ax1;
    sy1 = stp ? ax1 : ay1;
    if (sx0 > sx1) begin
      {sx0, sx1} = {sx1, sx0};
      {sy0, sy1} = {sy1, sy0};
    end
  end

  function automatic logic signed [16:0] round_q4(logic signed [16:0] v);
    logic signed [16:0] m;
    m = (v < 0) ? -v : v;
    m = (m + 17'sd8) >>> 4;
    return (v < 0) ? -m : m;
  endfunction

  logic signed [16:0] first_r, last_r, lim;
  always_comb begin
    first_r = round_q4(sx0);
    last_r  = round_q4(sx1);
    lim = stp ? 17'(IMG_HEIGHT - 1) : 17'(IMG_WIDTH - 1);
    if (first_r < 0) first_r = '0;
    if (last_r > lim) last_r = lim;
  end

  // restoring divider step on magnitudes: |dy|<<16 / |dx|
  logic [17:0] rem_sh;
  logic [16:0] dxm;
  always_comb begin
    dxm    = dx_q[16:0];
    rem_sh = {rem_q, quo_q[36]};
  end

  // minor offset of the current column, gradient stays within 18 bits
  logic signed [16:0] du_c;
  logic signed [34:0] gmul_c;
  always_comb begin
    du_c   = u_q * 17'sd16 - x0_q;
    gmul_c = g_q * du_c;
  end

  // pixel selection for current side
  logic signed [43:0] minor;
  logic               in_img;
  logic [AW-1:0]      paddr;
  always_comb begin
    minor = side_q ? base_q + 44'sd1 : base_q;
    if (steep_q) begin
      in_img = (minor >= 0) && (minor < IMG_WIDTH);
      paddr  = AW'(u_q * IMG_WIDTH + 17'(minor));
    end else begin
      in_img = (minor >= 0) && (minor < IMG_HEIGHT);
      paddr  = AW'(minor * IMG_WIDTH + 44'(u_q));
    end
  end

  logic [8:0] alpha_c;
  assign alpha_c = side_q ? {1'b0, f_q} : 9'd256 - {1'b0, f_q};

  // state sequencing
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (start_i) begin
        unique case (aald_pkg::req_e'(req_i.req_type))
          aald_pkg::REQ_LINE:  state_d = S_SETUP;
          aald_pkg::REQ_WRITE: state_d = S_PIX;
          aald_pkg::REQ_READ:  state_d = S_PIX;
          default:             state_d = S_DONE;
        endcase
      end
      S_PIX:   state_d = (req_q.req_type == aald_pkg::REQ_READ) ? S_RDRES : S_DONE;
      S_RDRES: state_d = S_DONE;
      S_SETUP: state_d = S_DIV;
      S_DIV:   if (cnt_q == '0) state_d = S_COL;
      S_COL:   state_d = (u_q > last_q) ? S_DONE : S_MUL;
      S_MUL:   state_d = S_PXA;
      S_PXA:   state_d = (in_img && alpha_c != '0) ? S_RDWT : (side_q ? S_COL : S_PXA);
      S_RDWT:  state_d = S_BLND;
      S_BLND:  state_d = S_WR;
      S_WR:    state_d = side_q ? S_COL : S_PXA;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_DONE);
    end
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = addr_q;
    mem_wdata = blend_q;
    if (state_q == S_PIX) begin
      mem_addr  = AW'(32'(req_q.pixel_row) * IMG_WIDTH + 32'(req_q.pixel_col));
      mem_wdata = req_q.pixel_value;
      mem_we    = (req_q.req_type == aald_pkg::REQ_WRITE) && pix_in_q;
    end else if (state_q == S_WR) begin
      mem_we = 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (start_i) begin
        req_q    <= req_i;
        res_q    <= '0;
        pix_in_q <= (32'(req_i.pixel_col) < IMG_WIDTH) &&
                    (32'(req_i.pixel_row) < IMG_HEIGHT);
      end
      S_PIX: if (req_q.req_type == aald_pkg::REQ_READ) res_q.was_read <= 1'b1;
      S_RDRES: if (pix_in_q) res_q.read_value <= mem_rdata_q;
      S_SETUP: begin
        steep_q <= stp;
        x0_q    <= sx0;
        y0_q    <= sy0;
        dx_q    <= sx1 - sx0;
        u_q     <= first_r;
        last_q  <= last_r;
        neg_q   <= (sy1 < sy0);
        quo_q   <= {1'b0, ((sy1 < sy0) ? 20'(sy0 - sy1) : 20'(sy1 - sy0)), 16'd0};
        rem_q   <= '0;
        cnt_q   <= 6'd37;
      end
      S_DIV: begin
        if (cnt_q != '0) begin
          if (rem_sh >= {1'b0, dxm}) begin
            rem_q <= 17'(rem_sh - {1'b0, dxm});
            quo_q <= {quo_q[35:0], 1'b1};
          end else begin
            rem_q <= rem_sh[16:0];
            quo_q <= {quo_q[35:0], 1'b0};
          end
          cnt_q <= cnt_q - 6'd1;
        end else begin
          if (dx_q == 0) g_q <= '0;
          else g_q <= neg_q ? -$signed({1'b0, quo_q[16:0]}) : $signed({1'b0, quo_q[16:0]});
        end
      end
      S_COL: begin
        ypos_q <= 64'(y0_q) * 64'sd65536 + 64'(gmul_c);
        side_q <= 1'b0;
      end
      S_MUL: begin
        base_q <= 44'(ypos_q >>> 20);
        f_q    <= ypos_q[19:12];
      end
      S_PXA: begin
        addr_q  <= paddr;
        alpha_q <= alpha_c;
        if (!(in_img && alpha_c != '0)) begin
          side_q <= 1'b1;
          if (side_q) u_q <= u_q + 17'sd1;
        end
      end
      S_BLND: blend_q <= 8'((17'(mem_rdata_q) * (17'd256 - 17'(alpha_q)) +
                             17'(req_q.ink) * 17'(alpha_q) + 17'd128) >> 8);
      S_WR: begin
        side_q <= 1'b1;
        if (side_q) u_q <= u_q + 17'sd1;
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
